>>> sv/mbcf_pkg.sv
// Shared constants, types and helpers for the mask boundary cell finder.
package mbcf_pkg;

  localparam int MaxRows = 1024;
  localparam int MaxCols = 1024;

  localparam int ROW_W     = $clog2(MaxRows);
  localparam int COL_W     = $clog2(MaxCols);
  localparam int DIM_W     = 11;
  localparam int CNT_W     = 20;
  localparam int CFG_IDX_W = 1;
  localparam int MIN_DIM   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS = 1'b0,
    CFG_GRID_COLS = 1'b1
  } cfg_idx_t;

  // Line buffer read data for one cell: row r-2 at c, row r-1 at c and c+1.
  typedef struct packed {
    logic above;
    logic centre;
    logic right;
  } lb_rd_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] top);
    logic [DIM_W-1:0] res;
    if (v < DIM_W'(MIN_DIM)) begin
      res = DIM_W'(MIN_DIM);
    end else if (v > top) begin
      res = top;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

>>> sv/mbcf_line_bufs.sv
// Two one-bit line buffers: older row and middle row, one write and three reads per cycle.
module mbcf_line_bufs
  import mbcf_pkg::*;
(
  input  logic             clk,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  output lb_rd_t           rd_data,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  logic             wr_older,
  input  logic             wr_middle
);

  logic older_mem  [MaxCols];
  logic middle_mem [MaxCols];
  logic [COL_W-1:0] rd_addr_nx;
  lb_rd_t rd_data_r;

  // Wraps at the top column; the result is never used there.
  assign rd_addr_nx = rd_addr + COL_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr]  <= wr_older;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r.above  <= older_mem[rd_addr];
      rd_data_r.centre <= middle_mem[rd_addr];
      rd_data_r.right  <= middle_mem[rd_addr_nx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/mask_boundary_cell_finder.sv
// Top level of the mask boundary cell finder.
// Usage: feed one mask bit per in_ transaction in raster order (columns inner,
// rows outer). For each interior cell whose mask is 0 and whose row or column
// central difference is nonzero, one out_ transaction carries the cell
// position, the inner neighbor and its index in the frame's boundary list.
// A cell is tested when the cell below it arrives, so its result follows that
// input bit.
// A result goes through the line buffer read and stage registers, loaded at the
// accepting edge, and then the output register, loaded when that stage
// advances.
// Throughput: one cell per cycle while no result waits at a stalled output; the
// line buffers give three reads and one write per cycle, which sets that figure.
// cfg_ transactions write grid_rows (index 0) and grid_cols (index 1); values
// are clamped to 3..1024. cfg_ready is always high.
// Reset: position and list counters clear, dimensions return to 1024x1024;
// line buffer contents are not cleared and are filled by the first two rows.
// When out_ready is low with a result pending, the stage behind the output
// register holds, and in_ready drops, only if that stage also has a result.
module mask_boundary_cell_finder
  import mbcf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mask_bit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROW_W-1:0]     out_cell_row,
  output logic [COL_W-1:0]     out_cell_col,
  output logic [ROW_W-1:0]     out_inner_row,
  output logic [COL_W-1:0]     out_inner_col,
  output logic [CNT_W-1:0]     out_list_index,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic [DIM_W-1:0] grid_rows_r, grid_rows_nxt;
  logic [DIM_W-1:0] grid_cols_r, grid_cols_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] found_r, found_nxt;

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_below_r;
  logic             s1_test_r;
  logic             s1_frame_end_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  logic             prev_centre_r;

  logic             out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0] out_cell_row_r, out_inner_row_r;
  logic [COL_W-1:0] out_cell_col_r, out_inner_col_r;
  logic [CNT_W-1:0] out_list_index_r;

  logic             in_acc, cfg_acc;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic             row_wrap, frame_end, test;
  lb_rd_t           rd;
  logic             hit, s1_adv, s1_done;
  logic [ROW_W-1:0] crow, irow;
  logic [COL_W-1:0] icol;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // Configuration registers.
  always_comb begin
    grid_rows_nxt = grid_rows_r;
    grid_cols_nxt = grid_cols_r;
    if (cfg_acc) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRID_ROWS: grid_rows_nxt = clamp_dim(cfg_data, DIM_W'(MaxRows));
        CFG_GRID_COLS: grid_cols_nxt = clamp_dim(cfg_data, DIM_W'(MaxCols));
        default: ;
      endcase
    end
  end

  // Raster position of the incoming cell.
  assign col_inc   = {1'b0, col_r} + DIM_W'(1);
  assign row_inc   = {1'b0, row_r} + DIM_W'(1);
  assign row_wrap  = col_inc >= grid_cols_r;
  assign frame_end = row_wrap && (row_inc >= grid_rows_r);
  assign test      = (row_r >= ROW_W'(2)) && (col_r != '0)
                     && (({1'b0, col_r} + DIM_W'(2)) <= grid_cols_r);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (in_acc) begin
      if (row_wrap) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  mbcf_line_bufs u_line_bufs (
    .clk       (clk),
    .rd_en     (in_acc),
    .rd_addr   (col_r),
    .rd_data   (rd),
    .wr_en     (s1_done),
    .wr_addr   (s1_col_r),
    .wr_older  (rd.centre),
    .wr_middle (s1_below_r)
  );

  // Evaluate stage: left neighbor is the previous cell's centre.
  assign hit = s1_valid_r && s1_test_r && !rd.centre
               && ((s1_below_r != rd.above) || (rd.right != prev_centre_r));
  assign s1_adv  = !hit || !out_valid_r || out_ready;
  assign s1_done = s1_valid_r && s1_adv;
  assign in_ready = s1_adv;
  assign in_acc   = in_valid && in_ready;

  assign crow = s1_row_r - ROW_W'(1);

  always_comb begin
    irow = crow;
    if (s1_below_r && !rd.above) begin
      irow = crow + ROW_W'(1);
    end else if (!s1_below_r && rd.above) begin
      irow = crow - ROW_W'(1);
    end
    icol = s1_col_r;
    if (rd.right && !prev_centre_r) begin
      icol = s1_col_r + COL_W'(1);
    end else if (!rd.right && prev_centre_r) begin
      icol = s1_col_r - COL_W'(1);
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Advance the list counter; clear it after the last cell of the frame.
  always_comb begin
    found_nxt = found_r;
    if (s1_done) begin
      if (s1_frame_end_r) begin
        found_nxt = '0;
      end else if (hit) begin
        found_nxt = found_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (hit && s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= DIM_W'(MaxRows);
      grid_cols_r <= DIM_W'(MaxCols);
      row_r       <= '0;
      col_r       <= '0;
      found_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      grid_rows_r <= grid_rows_nxt;
      grid_cols_r <= grid_cols_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      found_r     <= found_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_below_r     <= in_mask_bit;
      s1_test_r      <= test;
      s1_frame_end_r <= frame_end;
      s1_row_r       <= row_r;
      s1_col_r       <= col_r;
    end
    if (s1_done) begin
      prev_centre_r <= rd.centre;
    end
    if (hit && s1_adv) begin
      out_cell_row_r   <= crow;
      out_cell_col_r   <= s1_col_r;
      out_inner_row_r  <= irow;
      out_inner_col_r  <= icol;
      out_list_index_r <= found_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_row   = out_cell_row_r;
  assign out_cell_col   = out_cell_col_r;
  assign out_inner_row  = out_inner_row_r;
  assign out_inner_col  = out_inner_col_r;
  assign out_list_index = out_list_index_r;

endmodule

>>> tb/sv/tb_top.sv
// Testbench for the mask boundary cell finder: raster stimulus, boundary list prediction, scoreboard.
module tb_top;
  import mbcf_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    logic [ROW_W-1:0] inner_row;
    logic [COL_W-1:0] inner_col;
    logic [CNT_W-1:0] list_index;
  } boundary_t;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic                 in_mask_bit = 1'b0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [ROW_W-1:0]     out_cell_row;
  logic [COL_W-1:0]     out_cell_col;
  logic [ROW_W-1:0]     out_inner_row;
  logic [COL_W-1:0]     out_inner_col;
  logic [CNT_W-1:0]     out_list_index;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [DIM_W-1:0]     cfg_data    = '0;

  // Predictor state: line buffers, raster position, boundary count, grid size.
  bit               older_bits [MaxCols];
  bit               middle_bits [MaxCols];
  int unsigned      pos_row   = 0;
  int unsigned      pos_col   = 0;
  logic [CNT_W-1:0] found_cnt = '0;
  int unsigned      rows_cfg  = MaxRows;
  int unsigned      cols_cfg  = MaxCols;
  boundary_t        boundary_q [$];

  int fail_cnt     = 0;
  int cells_sent   = 0;
  int results_seen = 0;
  int reg_writes   = 0;
  int stall_cycles = 0;
  int rx_hold_req  = 0;
  bit in_idle_en   = 1'b1;
  bit out_idle_en  = 1'b1;

  mask_boundary_cell_finder u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mask_bit    (in_mask_bit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_row   (out_cell_row),
    .out_cell_col   (out_cell_col),
    .out_inner_row  (out_inner_row),
    .out_inner_col  (out_inner_col),
    .out_list_index (out_list_index),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (in_valid && !in_ready) stall_cycles++;
  end

  function automatic int unsigned limit_dim(logic [DIM_W-1:0] v, int unsigned top);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > top) return top;
    return 32'(v);
  endfunction

  // Advance the raster position by one cell and queue the boundary cell it completes.
  function automatic void predict_cell(bit below);
    int unsigned r, c;
    bit          above, centre, left, right;
    int          gx, gy, crow;
    boundary_t   e;
    r = pos_row;
    c = pos_col;
    if (c < MaxCols) begin
      above  = older_bits[c];
      centre = middle_bits[c];
      if (r >= 2 && c >= 1 && c + 2 <= cols_cfg && c + 1 < MaxCols) begin
        left  = older_bits[c-1];
        right = middle_bits[c+1];
        gx = int'(below) - int'(above);
        gy = int'(right) - int'(left);
        if (!centre && (gx != 0 || gy != 0)) begin
          crow         = r - 1;
          e.cell_row   = ROW_W'(crow);
          e.cell_col   = COL_W'(c);
          e.inner_row  = ROW_W'(crow + gx);
          e.inner_col  = COL_W'(int'(c) + gy);
          e.list_index = found_cnt;
          found_cnt++;
          boundary_q = {boundary_q, e};
        end
      end
      older_bits[c]  = centre;
      middle_bits[c] = below;
    end
    pos_col = c + 1;
    if (pos_col >= cols_cfg) begin
      pos_col = 0;
      pos_row = r + 1;
      if (pos_row >= rows_cfg) begin
        pos_row   = 0;
        found_cnt = '0;
      end
    end
  endfunction

  // Valid stays high on return; the caller sends again or lowers it in the same step.
  task automatic send_cell(bit b);
    int gap;
    gap = in_idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mask_bit <= b;
    do @(posedge clk); while (!in_ready);
    predict_cell(b);
    cells_sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_GRID_ROWS) rows_cfg = limit_dim(data, MaxRows);
    else cols_cfg = limit_dim(data, MaxCols);
    reg_writes++;
  endtask

  // Hold the input until every predicted result is out, then let the pipeline settle.
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (boundary_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_grid(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols);
    drain();
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_GRID_COLS, cols);
    cfg_valid <= 1'b0;
  endtask

  task automatic finish_frame();
    while (pos_row != 0 || pos_col != 0) send_cell(1'($urandom_range(0, 1)));
  endtask

  // Part of the first row at the reset size: nothing may come out while row 0 runs.
  task automatic test_default_dims();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    repeat (300) send_cell(1'($urandom_range(0, 1)));
    // shrink both dimensions below the position; the row wraps at the short width
    set_grid(DIM_W'(MIN_DIM), DIM_W'(MIN_DIM));
    finish_frame();
    drain();
  endtask

  // Out-of-range writes, then 3x3 frames with one neighbor pattern each.
  task automatic test_dim_clamp();
    logic [8:0] frame_pats [6] = '{9'h1EF, 9'h080, 9'h002, 9'h020, 9'h008, 9'h090};
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    write_reg(CFG_GRID_ROWS, '1);
    write_reg(CFG_GRID_COLS, '1);
    write_reg(CFG_GRID_ROWS, '0);
    write_reg(CFG_GRID_COLS, DIM_W'(2));
    cfg_valid <= 1'b0;
    foreach (frame_pats[i]) begin
      for (int k = 0; k < 9; k++) send_cell(frame_pats[i][k]);
    end
    drain();
  endtask

  // Full height, narrow grid: run many rows, then cut the height below the position.
  task automatic test_tall_grid();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b1;
    set_grid(DIM_W'(MaxRows), DIM_W'(MIN_DIM));
    repeat (50 * MIN_DIM) send_cell(1'($urandom_range(0, 1)));
    drain();
    write_reg(CFG_GRID_ROWS, DIM_W'(MIN_DIM));
    cfg_valid <= 1'b0;
    finish_frame();
    drain();
  endtask

  task automatic test_midframe_shrink();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    set_grid(DIM_W'(6), DIM_W'(8));
    repeat (2 * 8 + 5) send_cell(1'($urandom_range(0, 1)));
    drain();
    write_reg(CFG_GRID_COLS, DIM_W'(4));
    cfg_valid <= 1'b0;
    while (pos_row != 4 || pos_col != 2) send_cell(1'($urandom_range(0, 1)));
    drain();
    write_reg(CFG_GRID_ROWS, DIM_W'(MIN_DIM));
    cfg_valid <= 1'b0;
    finish_frame();
    drain();
  endtask

  // Stall the receiver for a long stretch while the sender keeps offering.
  task automatic test_output_stall();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    set_grid(DIM_W'(8), DIM_W'(32));
    rx_hold_req = 300;
    repeat (8 * 32) send_cell($urandom_range(0, 9) < 4);
    drain();
  endtask

  task automatic test_random_frames();
    int               frames, density, rnd_cells;
    logic [DIM_W-1:0] rows, cols;
    rnd_cells = 0;
    while (rnd_cells < 600) begin
      rows        = DIM_W'($urandom_range(3, 16));
      cols        = DIM_W'($urandom_range(3, 32));
      density     = $urandom_range(1, 9);
      frames      = $urandom_range(1, 2);
      in_idle_en  = ($urandom_range(0, 3) != 0);
      out_idle_en = ($urandom_range(0, 3) != 0);
      set_grid(rows, cols);
      repeat (frames * rows * cols) begin
        send_cell($urandom_range(0, 9) < density);
        rnd_cells++;
      end
    end
  endtask

  initial begin : result_checker
    boundary_t want, got;
    int        gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        gap = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        gap = out_idle_en ? $urandom_range(0, 3) : 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.cell_row   = out_cell_row;
      got.cell_col   = out_cell_col;
      got.inner_row  = out_inner_row;
      got.inner_col  = out_inner_col;
      got.list_index = out_list_index;
      results_seen++;
      if (boundary_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected transaction: cell (%0d,%0d) inner (%0d,%0d) index %0d",
                   got.cell_row, got.cell_col, got.inner_row, got.inner_col, got.list_index);
      end else begin
        want = boundary_q.pop_front();
        if (got.cell_row !== want.cell_row || got.cell_col !== want.cell_col ||
            got.inner_row !== want.inner_row || got.inner_col !== want.inner_col ||
            got.list_index !== want.list_index) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("mismatch: exp cell (%0d,%0d) inner (%0d,%0d) index %0d",
                     want.cell_row, want.cell_col, want.inner_row, want.inner_col,
                     want.list_index);
            $display("          got cell (%0d,%0d) inner (%0d,%0d) index %0d",
                     got.cell_row, got.cell_col, got.inner_row, got.inner_col,
                     got.list_index);
          end
        end
      end
    end
  end

  initial begin : run
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_dims();
    test_dim_clamp();
    test_tall_grid();
    test_midframe_shrink();
    test_output_stall();
    test_random_frames();
    drain();
    if (boundary_q.size() != 0) begin
      $display("%0d predicted boundary cells never came out", boundary_q.size());
      fail_cnt += boundary_q.size();
    end
    $display("Summary: %0d cells sent, %0d boundary results checked, %0d register writes",
             cells_sent, results_seen, reg_writes);
    $display("Reset-size raster, 3x3 up to full-height grids, mid-frame shrinks, %0d input stall cycles",
             stall_cycles);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
